[sv/fir_filter_unit_assert.svh]
`ifndef FIR_FILTER_UNIT_ASSERT_SVH
`define FIR_FILTER_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define FIR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define FIR_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[sv/fir_pkg.sv]
package fir_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int IDX_W    = 6;
    localparam int TAPCNT_W = 7;
    localparam int OUT_W    = 24;
    localparam int FRAC_W   = 15;
    localparam int IN_W     = 40;
    localparam int USER_W   = 2;
    localparam int CFG_IDX_W = 1;

    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST = 7'd64;

    typedef enum logic
    {
        FUNC_SAMPLE = 1'b0,
        FUNC_COEF   = 1'b1
    } fir_func_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_TAP_COUNT = 1'b0,
        REG_PRELOAD   = 1'b1
    } fir_reg_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } fir_state_t;

    typedef struct packed
    {
        logic                        shift;
        logic                        first;
        logic                        preload;
        logic signed [SAMPLE_W-1:0]  sample;
        logic                        coef_we;
        logic [IDX_W-1:0]            coef_index;
        logic signed [COEF_W-1:0]    coef_value;
        logic [TAPCNT_W-1:0]         tap_count;
    } fir_cell_ctrl_t;

endpackage

[sv/fir_cell.sv]
module fir_cell #(
    parameter int INDEX = 0,
    parameter int ACC_W = 38
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fir_pkg::fir_cell_ctrl_t             ctrl,
    input  logic signed [fir_pkg::SAMPLE_W-1:0] sample_in,
    input  logic signed [ACC_W-1:0]             acc_in,
    output logic signed [fir_pkg::SAMPLE_W-1:0] sample_out,
    output logic signed [ACC_W-1:0]             acc_out
);
    import fir_pkg::*;

    localparam logic [31:0] CELL_IDX = INDEX;

    logic signed [SAMPLE_W-1:0]        sample_reg, sample_next;
    logic signed [COEF_W-1:0]          coef_reg, coef_next;
    logic signed [ACC_W-1:0]           acc_reg, acc_next;
    logic signed [SAMPLE_W+COEF_W-1:0] product;
    logic signed [ACC_W-1:0]           term;
    logic                              active;
    logic                              fill_en;

    assign fill_en = ctrl.first && (CELL_IDX != 32'd0);
    assign active  = (CELL_IDX == 32'd0) || (32'(ctrl.tap_count) > CELL_IDX);
    assign product = sample_reg * coef_reg;

    always_comb
    begin
        sample_next = sample_reg;
        if (ctrl.shift)
        begin
            if (fill_en)
            begin
                sample_next = ctrl.preload ? ctrl.sample : '0;
            end
            else
            begin
                sample_next = sample_in;
            end
        end
    end

    always_comb
    begin
        coef_next = coef_reg;
        if (ctrl.coef_we && (32'(ctrl.coef_index) == CELL_IDX))
        begin
            coef_next = ctrl.coef_value;
        end
    end

    // partial sum moves one cell per cycle
    always_comb
    begin
        if (active)
        begin
            term = ACC_W'(product);
        end
        else
        begin
            term = '0;
        end
        acc_next = acc_in + term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            coef_reg   <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
            coef_reg   <= coef_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign sample_out = sample_reg;
    assign acc_out    = acc_reg;

endmodule

[sv/fir_filter_unit.sv]
// channel  | dir | signals                                   | carries
// s_axis   | in  | tvalid tready tdata[39:0] tuser[1:0]      | samples and coefficient writes
// m_axis   | out | tvalid tready tdata[23:0]                 | filtered samples
// cfg      | in  | cfg_we cfg_index[0:0] cfg_data[6:0]       | tap_count, preload_enable
//
// a sample transaction runs until its partial sum has moved down the whole tap chain,
// one cell per cycle, and then its result is loaded into the output register
// a coefficient transaction is written in the accepting cycle, no result
// the result sits in an output register; a new transaction is taken while it waits
// the result is held back only when the previous one is still not taken
// reset clears the delay line, the coefficients and preload_enable, and sets tap_count to 64

`include "fir_filter_unit_assert.svh"

module fir_filter_unit #(
    parameter int MAX_TAPS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // sample[15:0], coef_index[21:16], coef_value[37:22], zero pad
    input  logic [fir_pkg::IN_W-1:0]          s_axis_tdata,
    // func[0], first[1]
    input  logic [fir_pkg::USER_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // filtered[23:0]
    output logic [fir_pkg::OUT_W-1:0]         m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [fir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fir_pkg::TAPCNT_W-1:0]      cfg_data
);
    import fir_pkg::*;

    localparam int ACC_W = SAMPLE_W + COEF_W + $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(MAX_TAPS);
    localparam logic signed [ACC_W:0] SAT_HI   = (ACC_W+1)'(OUT_MAX);
    localparam logic signed [ACC_W:0] SAT_LO   = (ACC_W+1)'(OUT_MIN);
    localparam logic signed [ACC_W:0] RND_BIAS = (ACC_W+1)'((1 << FRAC_W) - 1);

    fir_state_t                 state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [TAPCNT_W-1:0]        tap_count_reg, tap_count_next;
    logic                       preload_reg, preload_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]    out_data_reg, out_data_next;

    logic                       accept;
    logic                       sample_acc;
    logic                       coef_acc;
    logic                       out_load;
    fir_func_t                  func;
    logic                       first;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           coef_index;
    logic signed [COEF_W-1:0]   coef_value;
    fir_cell_ctrl_t             ctrl;

    logic signed [SAMPLE_W-1:0] smp_chain [MAX_TAPS];
    logic signed [ACC_W-1:0]    acc_chain [MAX_TAPS];

    logic signed [ACC_W:0]      acc_ext;
    logic signed [ACC_W:0]      acc_rnd;
    logic signed [ACC_W:0]      acc_shr;
    logic signed [OUT_W-1:0]    result;

    assign func       = fir_func_t'(s_axis_tuser[0]);
    assign first      = s_axis_tuser[1];
    assign sample     = s_axis_tdata[15:0];
    assign coef_index = s_axis_tdata[21:16];
    assign coef_value = s_axis_tdata[37:22];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign sample_acc    = accept && (func == FUNC_SAMPLE);
    assign coef_acc      = accept && (func == FUNC_COEF);

    always_comb
    begin
        ctrl.shift      = sample_acc;
        ctrl.first      = first;
        ctrl.preload    = preload_reg;
        ctrl.sample     = sample;
        ctrl.coef_we    = coef_acc;
        ctrl.coef_index = coef_index;
        ctrl.coef_value = coef_value;
        ctrl.tap_count  = tap_count_reg;
    end

    genvar k;
    generate
        for (k = 0; k < MAX_TAPS; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                fir_cell #(
                    .INDEX (k),
                    .ACC_W (ACC_W)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .sample_in  (sample),
                    .acc_in     ({ACC_W{1'b0}}),
                    .sample_out (smp_chain[k]),
                    .acc_out    (acc_chain[k])
                );
            end
            else
            begin : g_body
                fir_cell #(
                    .INDEX (k),
                    .ACC_W (ACC_W)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .sample_in  (smp_chain[k-1]),
                    .acc_in     (acc_chain[k-1]),
                    .sample_out (smp_chain[k]),
                    .acc_out    (acc_chain[k])
                );
            end
        end
    endgenerate

    // shift right by 15, truncated toward zero, then saturate
    always_comb
    begin
        acc_ext = (ACC_W+1)'(acc_chain[MAX_TAPS-1]);
        if (acc_ext < 0)
        begin
            acc_rnd = acc_ext + RND_BIAS;
        end
        else
        begin
            acc_rnd = acc_ext;
        end
        acc_shr = acc_rnd >>> FRAC_W;
        if (acc_shr > SAT_HI)
        begin
            result = OUT_W'(SAT_HI);
        end
        else if (acc_shr < SAT_LO)
        begin
            result = OUT_W'(SAT_LO);
        end
        else
        begin
            result = acc_shr[OUT_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_acc)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg != CNT_DONE)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        tap_count_next = tap_count_reg;
        preload_next   = preload_reg;
        if (cfg_we)
        begin
            case (fir_reg_t'(cfg_index))
                REG_TAP_COUNT: tap_count_next = cfg_data;
                REG_PRELOAD:   preload_next   = cfg_data[0];
                default:       tap_count_next = tap_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            tap_count_reg <= TAP_COUNT_RST;
            preload_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            tap_count_reg <= tap_count_next;
            preload_reg   <= preload_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `FIR_ASSERT(a_sample_starts_run, sample_acc |=> (state_reg == ST_RUN) && (cnt_reg == '0), "sample transaction did not start a run")
    `FIR_ASSERT(a_load_after_chain, out_load |-> (cnt_reg == CNT_DONE), "result loaded before the partial sum left the chain")
    `FIR_ASSERT_NEVER(a_cnt_range, cnt_reg > CNT_DONE, "cycle counter past chain length")
    `FIR_ASSERT(a_coef_no_run, coef_acc |=> (state_reg == ST_IDLE) && !out_load, "coefficient transaction started a run")

endmodule

[tb/sv/testbench.sv]
module testbench;
    import fir_pkg::*;

    localparam int MAX_TAPS       = 64;
    localparam int DRAIN_CYCLES   = MAX_TAPS + 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 215;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata;
    logic [USER_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_W-1:0]       m_axis_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [TAPCNT_W-1:0]    cfg_data;

    // filter state as seen from the stream
    logic signed [SAMPLE_W-1:0] sample_hist [MAX_TAPS];
    logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
    logic [TAPCNT_W-1:0]        taps_cfg;
    logic                       preload_cfg;
    logic signed [OUT_W-1:0]    filtered_q [$];

    int   err_count = 0;
    int   idle_cycles = 0;
    int   rx_stall = 0;
    logic rx_throttle = 1'b0;
    logic tx_quiet = 1'b0;

    fir_filter_unit #(
        .MAX_TAPS(MAX_TAPS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'h8000;
        else if (r < 20)
            return 16'h7fff;
        else if (r < 25)
            return 16'h0000;
        else
            return 16'($urandom);
    endfunction

    function automatic int pick_pause();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic filter_step(fir_func_t func, logic first, logic signed [15:0] sample,
                               logic [5:0] idx, logic signed [15:0] cval);
        int     n;
        longint acc;
        longint y;
        if (func == FUNC_COEF)
        begin
            if (int'(idx) < MAX_TAPS)
                coef_mem[idx] = cval;
        end
        else
        begin
            if (first)
            begin
                for (int i = 0; i < MAX_TAPS; i++)
                    sample_hist[i] = preload_cfg ? sample : '0;
            end
            for (int i = MAX_TAPS - 1; i > 0; i--)
                sample_hist[i] = sample_hist[i-1];
            sample_hist[0] = sample;
            if (taps_cfg == 0)
                n = 1;
            else if (int'(taps_cfg) > MAX_TAPS)
                n = MAX_TAPS;
            else
                n = int'(taps_cfg);
            acc = 0;
            for (int i = 0; i < n; i++)
                acc += longint'(coef_mem[i]) * longint'(sample_hist[i]);
            // shift toward zero
            if (acc < 0)
                y = -((-acc) >>> FRAC_W);
            else
                y = acc >>> FRAC_W;
            if (y > OUT_MAX)
                y = OUT_MAX;
            if (y < OUT_MIN)
                y = OUT_MIN;
            filtered_q.push_back(y[OUT_W-1:0]);
        end
    endtask

    task automatic send_item(fir_func_t func, logic first, logic [15:0] sample,
                             logic [5:0] idx, logic [15:0] cval);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, cval, idx, sample};
        s_axis_tuser  <= {first, func};
        do
            @(posedge clk);
        while (!s_axis_tready);
        filter_step(func, first, sample, idx, cval);
    endtask

    task automatic pace();
        int n;
        n = 0;
        if (!tx_quiet && $urandom_range(99) >= 55)
            n = pick_pause();
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_sample(logic first, logic [15:0] sample);
        send_item(FUNC_SAMPLE, first, sample, 6'($urandom), 16'($urandom));
        pace();
    endtask

    task automatic send_coef(logic [5:0] idx, logic [15:0] cval);
        send_item(FUNC_COEF, 1'($urandom), 16'($urandom), idx, cval);
        pace();
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (filtered_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(fir_reg_t idx, logic [TAPCNT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == REG_TAP_COUNT)
            taps_cfg = data;
        else
            preload_cfg = data[0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_history();
        // coefficients are zero after reset, samples before any stream start
        send_sample(1'b0, 16'h7fff);
        send_sample(1'b0, 16'h8000);
        send_coef(6'd0, 16'h7fff);
        send_coef(6'd63, 16'h8000);
        send_coef(6'd1, 16'h8000);
        send_sample(1'b0, 16'h7fff);
        send_sample(1'b0, 16'h8000);
    endtask

    task automatic test_stream_start();
        send_sample(1'b1, 16'h8000);
        send_sample(1'b0, 16'h7fff);
        send_sample(1'b0, 16'h7fff);
        wait_idle();
        write_reg(REG_PRELOAD, 7'h7f);
        send_sample(1'b1, 16'h7fff);
        send_sample(1'b0, 16'h0000);
        send_sample(1'b1, 16'h8000);
        send_sample(1'b0, 16'h8000);
    endtask

    task automatic test_unused_fields();
        // first mark on a coefficient write must not restart the stream
        send_item(FUNC_COEF, 1'b1, 16'hffff, 6'd2, 16'h4000);
        pace();
        send_item(FUNC_SAMPLE, 1'b0, 16'h1234, 6'h3f, 16'hffff);
        pace();
        send_item(FUNC_SAMPLE, 1'b0, 16'hedcb, 6'h00, 16'h0000);
        pace();
    endtask

    task automatic run_phase(logic [TAPCNT_W-1:0] taps, logic preload, logic quiet);
        int       sent;
        int       r;
        int       len;
        logic [5:0] junk;
        wait_idle();
        junk = 6'($urandom);
        write_reg(REG_TAP_COUNT, taps);
        write_reg(REG_PRELOAD, {junk, preload});
        tx_quiet    = quiet;
        rx_throttle = !quiet;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 3)
            begin
                drain_results();
            end
            else if (r < 88)
            begin
                len = $urandom_range(1, 90);
                send_sample(1'b1, pick_value());
                sent++;
                for (int k = 0; k < len && sent < PHASE_ITEMS; k++)
                begin
                    if ($urandom_range(99) < 8)
                        send_coef(6'($urandom), pick_value());
                    else
                        send_sample(1'b0, pick_value());
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_item(fir_func_t'($urandom_range(1)), 1'($urandom), pick_value(),
                              6'($urandom), pick_value());
                    pace();
                    sent++;
                end
            end
        end
    endtask

    task automatic test_config_sweep();
        run_phase(7'd1, 1'b0, 1'b1);
        run_phase(7'd0, 1'b1, 1'b0);
        run_phase(7'd64, 1'b1, 1'b0);
        run_phase(7'd127, 1'b0, 1'b1);
        run_phase(7'd2, 1'b1, 1'b0);
        run_phase(7'd63, 1'b0, 1'b0);
        run_phase(7'd65, 1'b1, 1'b1);
        run_phase(7'($urandom_range(127)), 1'($urandom), 1'b0);
        run_phase(7'($urandom_range(127)), 1'($urandom), 1'b0);
    endtask

    initial
    begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_TAP_COUNT;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            sample_hist[i] = '0;
            coef_mem[i]    = '0;
        end
        taps_cfg    = TAP_COUNT_RST;
        preload_cfg = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        rx_throttle = 1'b1;
        test_reset_history();
        test_stream_start();
        test_unused_fields();
        test_config_sweep();
        wait_idle();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side backpressure
    always @(posedge clk)
    begin
        if (rx_stall > 0)
        begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_throttle && $urandom_range(99) < 30)
        begin
            rx_stall = pick_pause() - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        logic signed [OUT_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (filtered_q.size() == 0)
            begin
                $error("filtered: unexpected transaction, actual %0d",
                       $signed(m_axis_tdata));
                err_count++;
            end
            else
            begin
                want = filtered_q.pop_front();
                if (m_axis_tdata !== want)
                begin
                    $error("filtered: expected %0d, actual %0d", want, $signed(m_axis_tdata));
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule

[filelist.f]
+incdir+sv
sv/fir_pkg.sv
sv/fir_cell.sv
sv/fir_filter_unit.sv
tb/sv/testbench.sv
